// File: rtl/svm_pkg.sv
// ----------------------------------------------------------------------------
// svm_pkg: shared types and constants of the saturating voice mixer
// Transaction payloads, command and result codes, voice table entry layout.
// ----------------------------------------------------------------------------
package svm_pkg;

	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_START = 2'd1;
	localparam logic [1:0] CMD_TICK  = 2'd2;

	localparam logic KIND_MIX   = 1'b0;
	localparam logic KIND_START = 1'b1;

	localparam int unsigned BLOCK_WIDTH = 13;
	localparam logic [BLOCK_WIDTH-1:0] BLOCK_MAX = 13'd4096;
	localparam logic [BLOCK_WIDTH-1:0] BLOCK_MIN = 13'd1;

	localparam logic signed [15:0] MIX_CEIL  = 16'sh7fff;
	localparam logic signed [15:0] MIX_FLOOR = 16'sh8000;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [15:0]        address;
		logic signed [15:0] value;
		logic [16:0]        length;
		logic               repeat_req;
	} req_t;

	typedef struct packed {
		logic               kind;
		logic signed [15:0] mixed;
		logic               started;
		logic               block_end;
	} rsp_t;

	typedef struct packed {
		logic [15:0] start;
		logic [16:0] length;
		logic [16:0] cursor;
		logic        loops;
	} voice_t;

endpackage

// File: rtl/svm_voice_table.sv
// ----------------------------------------------------------------------------
// svm_voice_table: voice table storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module svm_voice_table #(
	parameter int VOICES = 32,
	parameter int VW = 5
) (
	input  logic            clk,
	input  logic            wr_en,
	input  logic [VW-1:0]   wr_addr,
	input  svm_pkg::voice_t wr_data,
	input  logic [VW-1:0]   rd_addr,
	output svm_pkg::voice_t rd_data
);

	svm_pkg::voice_t mem [VOICES];
	svm_pkg::voice_t rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	assign rd_data = rd_q;

endmodule

// File: rtl/saturating_voice_mixer_unit.sv
// ----------------------------------------------------------------------------
// saturating_voice_mixer_unit: multi-voice PCM mixer with saturation
// Sample memory, voice table, and a sequencer that mixes one sample per tick.
// ----------------------------------------------------------------------------
// A sample write is done in the idle state; a start command goes on to the post
// state and waits there for the result register. A tick walks the active voices
// in table order over one voice table port and one sample memory port: a playing
// voice passes the read, memory and add states, a silent one only read and memory.
// At a block boundary a second walk from the highest slot down checks each voice
// and, for each removed one-shot voice, copies the last entry over it.
// SAMPLE_WORDS must be a power of two, which the block itself does not
// enforce; addresses wrap on its low bits. Sample words read before they
// are written return undefined data.
module saturating_voice_mixer_unit #(
	parameter int VOICES = 32,
	parameter int SAMPLE_WORDS = 65536
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  svm_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output svm_pkg::rsp_t rsp,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [12:0]   cfg_data
);

	localparam int AW  = $clog2(SAMPLE_WORDS);
	localparam int VW  = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int CW  = $clog2(VOICES + 1);
	localparam int RW  = (AW > 18) ? AW : 18;
	localparam int WW  = (AW > 16) ? AW : 16;

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_T_RD  = 9'b000000010,
		ST_T_MEM = 9'b000000100,
		ST_T_ADD = 9'b000001000,
		ST_T_END = 9'b000010000,
		ST_R_RD  = 9'b000100000,
		ST_R_CHK = 9'b001000000,
		ST_R_CPY = 9'b010000000,
		ST_POST  = 9'b100000000
	} state_t;

	state_t                          state_q;
	logic [CW-1:0]                   cnt_q;
	logic [CW-1:0]                   idx_q;
	logic [11:0]                     pos_q;
	logic [svm_pkg::BLOCK_WIDTH-1:0] bsz_q;
	logic signed [15:0]              sum_q;
	svm_pkg::rsp_t                   res_q;
	svm_pkg::rsp_t                   out_q;
	logic                            out_valid_q;

	logic [15:0]     smem [SAMPLE_WORDS];
	logic [15:0]     smem_rd_q;
	logic [AW-1:0]   smem_raddr;
	logic [AW-1:0]   smem_waddr;
	logic [RW-1:0]   rd_ext;
	logic [WW-1:0]   wr_ext;
	logic [17:0]     rd_sum;

	logic            vt_we;
	logic [VW-1:0]   vt_waddr;
	svm_pkg::voice_t vt_wdata;
	logic [VW-1:0]   vt_raddr;
	svm_pkg::voice_t vt_rd;

	logic            req_fire;
	logic            slot_free;
	logic            playing;
	logic            ended;
	logic [CW-1:0]   idx_next;
	logic [CW-1:0]   idx_prev;
	logic [CW-1:0]   last;
	logic            blk_end;
	logic signed [16:0] acc;
	logic signed [15:0] sat;

	assign req_ready = (state_q == ST_IDLE);
	assign req_fire  = req_valid && req_ready;
	assign slot_free = !out_valid_q || rsp_ready;
	assign cfg_ready = 1'b1;
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	assign playing  = vt_rd.cursor < vt_rd.length;
	assign ended    = vt_rd.cursor == vt_rd.length;
	assign idx_next = idx_q + CW'(1);
	assign idx_prev = idx_q - CW'(1);
	assign last     = cnt_q - CW'(1);
	assign blk_end  = ({1'b0, pos_q} + 13'd1) >= bsz_q;

	assign rd_sum     = {2'b00, vt_rd.start} + {1'b0, vt_rd.cursor};
	assign rd_ext     = RW'(rd_sum);
	assign smem_raddr = rd_ext[AW-1:0];
	assign wr_ext     = WW'(req.address);
	assign smem_waddr = wr_ext[AW-1:0];

	assign acc = {sum_q[15], sum_q} + {smem_rd_q[15], $signed(smem_rd_q)};
	assign sat = (acc[16] != acc[15])
		? (acc[16] ? svm_pkg::MIX_FLOOR : svm_pkg::MIX_CEIL)
		: acc[15:0];

	always_comb begin
		vt_we    = 1'b0;
		vt_waddr = idx_q[VW-1:0];
		vt_wdata = vt_rd;
		vt_raddr = idx_q[VW-1:0];
		case (state_q)
			ST_IDLE: begin
				vt_waddr       = cnt_q[VW-1:0];
				vt_wdata.start  = req.address;
				vt_wdata.length = req.length;
				vt_wdata.cursor = '0;
				vt_wdata.loops  = req.repeat_req;
				vt_we = req_fire && (req.cmd == svm_pkg::CMD_START)
					&& (cnt_q < CW'(VOICES));
			end
			ST_T_MEM: begin
				vt_wdata.cursor = vt_rd.cursor + 17'd1;
				vt_we           = playing;
			end
			ST_R_RD: begin
				vt_raddr = idx_prev[VW-1:0];
			end
			ST_R_CHK: begin
				vt_waddr        = idx_prev[VW-1:0];
				vt_wdata.cursor = '0;
				vt_we           = ended && vt_rd.loops;
				vt_raddr        = last[VW-1:0];
			end
			ST_R_CPY: begin
				vt_waddr = idx_prev[VW-1:0];
				vt_we    = 1'b1;
			end
			default: begin
			end
		endcase
	end

	svm_voice_table #(
		.VOICES(VOICES),
		.VW(VW)
	) u_voice_table (
		.clk(clk),
		.wr_en(vt_we),
		.wr_addr(vt_waddr),
		.wr_data(vt_wdata),
		.rd_addr(vt_raddr),
		.rd_data(vt_rd)
	);

	always_ff @(posedge clk) begin
		if (req_fire && (req.cmd == svm_pkg::CMD_WRITE)) begin
			smem[smem_waddr] <= req.value;
		end
		smem_rd_q <= smem[smem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bsz_q <= svm_pkg::BLOCK_MAX;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_data == '0) begin
				bsz_q <= svm_pkg::BLOCK_MIN;
			end else if (cfg_data > svm_pkg::BLOCK_MAX) begin
				bsz_q <= svm_pkg::BLOCK_MAX;
			end else begin
				bsz_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				sum_q             <= '0;
				res_q.kind        <= svm_pkg::KIND_START;
				res_q.mixed       <= '0;
				res_q.started     <= cnt_q < CW'(VOICES);
				res_q.block_end   <= 1'b0;
			end
			ST_T_ADD: begin
				sum_q <= sat;
			end
			ST_T_END: begin
				res_q.kind      <= svm_pkg::KIND_MIX;
				res_q.mixed     <= sum_q;
				res_q.started   <= 1'b0;
				res_q.block_end <= blk_end;
			end
			default: begin
			end
		endcase
		if (state_q == ST_POST && slot_free) begin
			out_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			idx_q       <= '0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= (state_q == ST_POST && slot_free) || (out_valid_q && !rsp_ready);
			case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					if (req_fire) begin
						case (req.cmd)
							svm_pkg::CMD_START: begin
								if (cnt_q < CW'(VOICES)) begin
									cnt_q <= cnt_q + CW'(1);
								end
								state_q <= ST_POST;
							end
							svm_pkg::CMD_TICK: begin
								state_q <= (cnt_q == '0) ? ST_T_END : ST_T_RD;
							end
							default: begin
							end
						endcase
					end
				end
				ST_T_RD: begin
					state_q <= ST_T_MEM;
				end
				ST_T_MEM: begin
					if (playing) begin
						state_q <= ST_T_ADD;
					end else begin
						idx_q   <= idx_next;
						state_q <= (idx_next == cnt_q) ? ST_T_END : ST_T_RD;
					end
				end
				ST_T_ADD: begin
					idx_q   <= idx_next;
					state_q <= (idx_next == cnt_q) ? ST_T_END : ST_T_RD;
				end
				ST_T_END: begin
					if (blk_end) begin
						pos_q   <= '0;
						idx_q   <= cnt_q;
						state_q <= (cnt_q == '0) ? ST_POST : ST_R_RD;
					end else begin
						pos_q   <= pos_q + 12'd1;
						state_q <= ST_POST;
					end
				end
				ST_R_RD: begin
					state_q <= ST_R_CHK;
				end
				ST_R_CHK: begin
					if (ended && !vt_rd.loops) begin
						state_q <= ST_R_CPY;
					end else begin
						idx_q   <= idx_prev;
						state_q <= (idx_prev == '0) ? ST_POST : ST_R_RD;
					end
				end
				ST_R_CPY: begin
					cnt_q   <= last;
					idx_q   <= idx_prev;
					state_q <= (idx_prev == '0) ? ST_POST : ST_R_RD;
				end
				ST_POST: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: rtl/svm_checker.sv
// ----------------------------------------------------------------------------
// svm_checker: port-level checks of the voice mixer
// Result transaction hold, result field coding, and command sequencing.
// ----------------------------------------------------------------------------
module svm_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input svm_pkg::req_t req,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input svm_pkg::rsp_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result transaction changed while stalled");

	a_busy_after_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready
		&& (req.cmd == svm_pkg::CMD_START || req.cmd == svm_pkg::CMD_TICK)
		|=> !req_ready)
		else $error("new transaction taken while a command is in progress");

	a_rsp_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(!req_ready))
		else $error("result appeared without a command in progress");

	a_start_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.kind == svm_pkg::KIND_START
		|-> rsp.mixed == '0 && !rsp.block_end)
		else $error("start status carries mix fields");

	a_mix_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.kind == svm_pkg::KIND_MIX |-> !rsp.started)
		else $error("mixed sample carries start status");

endmodule

bind saturating_voice_mixer_unit svm_checker u_svm_checker (
	.clk(clk),
	.arst_n(arst_n),
	.req_valid(req_valid),
	.req_ready(req_ready),
	.req(req),
	.rsp_valid(rsp_valid),
	.rsp_ready(rsp_ready),
	.rsp(rsp)
);

// File: dv/saturating_voice_mixer_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// saturating_voice_mixer_unit_tb: self-checking bench for the voice mixer
// Drives sample writes, voice starts and ticks over the request channel and
// tracks sample memory, voice table and block position in a local model.
// Each response is checked against that model in order. Directed tests cover
// saturation, block resizing, wraparound, zero-length and looping voices, and
// a long response stall. Random phases then run at several block sizes with
// random idling on both channels in all but the last. Sample words are written
// before any voice reads them.
// ----------------------------------------------------------------------------
module saturating_voice_mixer_unit_tb;

	localparam int VOICES = 32;
	localparam int SAMPLE_WORDS = 65536;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 300;
	localparam int RSP_HOLD_CYCLES = 600;
	localparam int PHASE_ITEMS = 205;

	logic          clk = 1'b0;
	logic          arst_n;
	logic          req_valid;
	logic          req_ready;
	svm_pkg::req_t req;
	logic          rsp_valid;
	logic          rsp_ready;
	svm_pkg::rsp_t rsp;
	logic          cfg_valid;
	logic          cfg_ready;
	logic [12:0]   cfg_data;

	bit idle_on = 1'b1;
	bit rsp_hold_req = 1'b0;
	int fail_count = 0;
	int sent_count = 0;

	logic signed [15:0] pcm_mem [SAMPLE_WORDS];
	bit                 pcm_written [SAMPLE_WORDS];
	svm_pkg::voice_t    voice_tab [VOICES];
	int                 voice_count = 0;
	int                 block_pos = 0;
	int                 block_len = int'(svm_pkg::BLOCK_MAX);
	svm_pkg::rsp_t      mix_expected [$];

	saturating_voice_mixer_unit #(
		.VOICES(VOICES),
		.SAMPLE_WORDS(SAMPLE_WORDS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic void apply_block_size(input logic [12:0] v);
		if (v == 0) begin
			block_len = int'(svm_pkg::BLOCK_MIN);
		end else if (v > svm_pkg::BLOCK_MAX) begin
			block_len = int'(svm_pkg::BLOCK_MAX);
		end else begin
			block_len = int'(v);
		end
	endfunction

	function automatic void predict_request(input svm_pkg::req_t r);
		svm_pkg::rsp_t res;
		int            acc;
		logic [15:0]   addr;
		res = '0;
		case (r.cmd)
			svm_pkg::CMD_WRITE: begin
				pcm_mem[r.address] = r.value;
				pcm_written[r.address] = 1'b1;
			end
			svm_pkg::CMD_START: begin
				res.kind = svm_pkg::KIND_START;
				if (voice_count < VOICES) begin
					voice_tab[voice_count] = '{start: r.address, length: r.length,
						cursor: '0, loops: r.repeat_req};
					voice_count++;
					res.started = 1'b1;
				end
				mix_expected.push_back(res);
			end
			svm_pkg::CMD_TICK: begin
				acc = 0;
				for (int i = 0; i < voice_count; i++) begin
					if (voice_tab[i].cursor < voice_tab[i].length) begin
						addr = voice_tab[i].start + voice_tab[i].cursor[15:0];
						acc = acc + pcm_mem[addr];
						if (acc > svm_pkg::MIX_CEIL) acc = svm_pkg::MIX_CEIL;
						if (acc < svm_pkg::MIX_FLOOR) acc = svm_pkg::MIX_FLOOR;
						voice_tab[i].cursor = voice_tab[i].cursor + 17'd1;
					end
				end
				res.kind = svm_pkg::KIND_MIX;
				res.mixed = acc[15:0];
				res.block_end = (block_pos + 1 >= block_len);
				if (res.block_end) begin
					block_pos = 0;
					for (int i = voice_count - 1; i >= 0; i--) begin
						if (voice_tab[i].cursor == voice_tab[i].length) begin
							if (voice_tab[i].loops) begin
								voice_tab[i].cursor = '0;
							end else begin
								voice_tab[i] = voice_tab[voice_count - 1];
								voice_count--;
							end
						end
					end
				end else begin
					block_pos++;
				end
				mix_expected.push_back(res);
			end
			default: ;
		endcase
	endfunction

	function automatic svm_pkg::req_t rand_payload(input logic [1:0] cmd);
		svm_pkg::req_t r;
		r.cmd = cmd;
		r.address = 16'($urandom_range(0, 16'hffff));
		r.value = 16'($urandom_range(0, 16'hffff));
		r.length = 17'($urandom_range(0, 17'h1ffff));
		r.repeat_req = 1'($urandom_range(0, 1));
		return r;
	endfunction

	task automatic send_item(input svm_pkg::req_t item);
		@(negedge clk);
		if (idle_on && $urandom_range(0, 7) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		req <= item;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		sent_count++;
		predict_request(item);
	endtask

	task automatic send_write(input logic [15:0] addr, input logic signed [15:0] val);
		svm_pkg::req_t item;
		item = rand_payload(svm_pkg::CMD_WRITE);
		item.address = addr;
		item.value = val;
		send_item(item);
	endtask

	task automatic send_start(input logic [15:0] addr, input logic [16:0] len,
			input logic loops);
		svm_pkg::req_t item;
		item = rand_payload(svm_pkg::CMD_START);
		item.address = addr;
		item.length = len;
		item.repeat_req = loops;
		send_item(item);
	endtask

	// fill every sample word this tick will read before issuing it
	task automatic send_tick();
		logic [15:0] addr;
		for (int i = 0; i < voice_count; i++) begin
			if (voice_tab[i].cursor < voice_tab[i].length) begin
				addr = voice_tab[i].start + voice_tab[i].cursor[15:0];
				if (!pcm_written[addr]) begin
					send_write(addr, 16'($urandom_range(0, 16'hffff)));
				end
			end
		end
		send_item(rand_payload(svm_pkg::CMD_TICK));
	endtask

	task automatic wait_drain();
		@(negedge clk);
		req_valid <= 1'b0;
		while (mix_expected.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_block_size(input logic [12:0] v);
		@(negedge clk);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		apply_block_size(v);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_idle_commands();
		svm_pkg::req_t item;
		send_tick();
		item = '1;
		item.cmd = CMD_UNUSED;
		send_item(item);
	endtask

	task automatic test_saturation();
		send_write(16'h0010, svm_pkg::MIX_CEIL);
		send_write(16'h0011, svm_pkg::MIX_FLOOR);
		send_start(16'h0010, 17'd1, 1'b0);
		send_start(16'h0010, 17'd1, 1'b0);
		send_start(16'h0011, 17'd1, 1'b0);
		send_start(16'h0011, 17'd1, 1'b0);
		send_tick();
	endtask

	task automatic test_block_shrink();
		send_tick();
		wait_drain();
		write_block_size(13'd0);
		send_tick();
		send_tick();
		wait_drain();
		write_block_size(13'h1fff);
	endtask

	task automatic test_wrap_long();
		send_start(16'hfffe, 17'h10000, 1'b0);
		send_start(16'hffff, 17'h1ffff, 1'b1);
		repeat (3) send_tick();
	endtask

	task automatic test_zero_length();
		send_start(16'h0100, 17'd0, 1'b0);
		send_start(16'h0101, 17'd0, 1'b1);
		send_tick();
	endtask

	task automatic test_loop_restart();
		wait_drain();
		write_block_size(13'd2);
		send_start(16'h0200, 17'd1, 1'b1);
		send_start(16'h0201, 17'd3, 1'b0);
		repeat (4) send_tick();
	endtask

	task automatic test_backpressure();
		rsp_hold_req = 1'b1;
		repeat (30) send_tick();
		wait_drain();
	endtask

	task automatic test_random_phases();
		logic [12:0]   sizes [8];
		svm_pkg::req_t item;
		int            phase_base;
		int            pick;
		int            loopers;
		int            longs;
		sizes = '{13'd4096, 13'd16, 13'd0, 13'd5, 13'd4096, 13'd4097, 13'd1, 13'd3};
		for (int p = 0; p < 8; p++) begin
			if (p == 7) idle_on = 1'b0;
			wait_drain();
			write_block_size(p == 5 ? 13'($urandom_range(1, 13'h1fff)) : sizes[p]);
			phase_base = sent_count;
			while (sent_count - phase_base < PHASE_ITEMS) begin
				pick = $urandom_range(0, 99);
				if (pick < 5) begin
					send_item(rand_payload(CMD_UNUSED));
				end else if (pick < 30) begin
					item = rand_payload(svm_pkg::CMD_WRITE);
					if ($urandom_range(0, 1)) item.address = 16'($urandom_range(0, 255));
					if ($urandom_range(0, 4) == 0) begin
						item.value = $urandom_range(0, 1) ? svm_pkg::MIX_CEIL
							: svm_pkg::MIX_FLOOR;
					end
					send_item(item);
				end else if (pick < 52) begin
					loopers = 0;
					longs = 0;
					for (int i = 0; i < voice_count; i++) begin
						if (voice_tab[i].loops) loopers++;
						if (voice_tab[i].length > 4096) longs++;
					end
					item = rand_payload(svm_pkg::CMD_START);
					item.repeat_req = (loopers < 4) && ($urandom_range(0, 7) == 0);
					pick = $urandom_range(0, 49);
					if (pick == 0 && longs < 3) begin
						item.length = 17'($urandom_range(4097, 17'h1ffff));
					end else if (pick < 5) begin
						item.length = '0;
					end else begin
						item.length = 17'($urandom_range(1, 40));
					end
					if ($urandom_range(0, 9) < 7) item.address = 16'($urandom_range(0, 255));
					send_item(item);
				end else begin
					send_tick();
				end
			end
		end
	endtask

	initial begin
		rsp_ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (rsp_hold_req) begin
				rsp_ready <= 1'b0;
				repeat (RSP_HOLD_CYCLES) @(negedge clk);
				rsp_hold_req = 1'b0;
			end else if (idle_on && $urandom_range(0, 9) == 0) begin
				rsp_ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(negedge clk);
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : check_results
		svm_pkg::rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (mix_expected.size() == 0) begin
				$error("result with no transaction pending: kind %0d mixed %0d",
					rsp.kind, rsp.mixed);
				fail_count++;
			end else begin
				want = mix_expected.pop_front();
				if (rsp.kind !== want.kind) begin
					$error("kind: expected %0d, got %0d", want.kind, rsp.kind);
					fail_count++;
				end
				if (rsp.mixed !== want.mixed) begin
					$error("mixed: expected %0d, got %0d", want.mixed, rsp.mixed);
					fail_count++;
				end
				if (rsp.started !== want.started) begin
					$error("started: expected %0d, got %0d", want.started, rsp.started);
					fail_count++;
				end
				if (rsp.block_end !== want.block_end) begin
					$error("block_end: expected %0d, got %0d", want.block_end,
						rsp.block_end);
					fail_count++;
				end
			end
		end
	end

	initial begin
		#(10_000_000);
		$display("FAILURE");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_idle_commands();
		test_saturation();
		test_block_shrink();
		test_wrap_long();
		test_zero_length();
		test_loop_restart();
		test_backpressure();
		test_random_phases();
		wait_drain();
		if (fail_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
